/* rtl/joystick_scale_and_direction_assert.svh */
// Assertion macros for the joystick scale and direction block.
// Expects clk and rst in the scope of the file that includes it.
`ifndef JOYSTICK_SCALE_AND_DIRECTION_ASSERT_SVH
`define JOYSTICK_SCALE_AND_DIRECTION_ASSERT_SVH

// pre implies post in the same cycle, checked outside reset
`define JSD_CHECK_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("jsd check failed: lbl");

// post holds in the cycle after reset is high
`define JSD_CHECK_AFTER_RESET(lbl, post) \
  lbl: assert property (@(posedge clk) rst |=> (post)) \
    else $error("jsd reset check failed: lbl");

`endif

/* rtl/jsd_pkg.sv */
// Shared types and constants of the joystick scale and direction block.
// No dependencies.
package jsd_pkg;

  localparam int NEUTRAL_W = 8;
  localparam int LIMIT_W   = 7;
  localparam int PCT_W     = 8;
  localparam int DIR_W     = 3;
  localparam int QUOT_BITS = 7;    // quotient never exceeds 100
  localparam int PCT_FULL  = 100;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int MID_DEPTH = 2;

  localparam logic [NEUTRAL_W-1:0] NEUTRAL_RESET     = 8'd128;
  localparam logic [LIMIT_W-1:0]   DEAD_ZONE_RESET   = 7'd10;
  localparam logic [LIMIT_W-1:0]   CROSS_LIMIT_RESET = 7'd50;

  localparam logic [1:0] REG_NEUTRAL_X   = 2'd0;
  localparam logic [1:0] REG_NEUTRAL_Y   = 2'd1;
  localparam logic [1:0] REG_DEAD_ZONE   = 2'd2;
  localparam logic [1:0] REG_CROSS_LIMIT = 2'd3;

  localparam logic [DIR_W-1:0] DIR_NEUTRAL = 3'd0;
  localparam logic [DIR_W-1:0] DIR_UP      = 3'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN    = 3'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT    = 3'd3;
  localparam logic [DIR_W-1:0] DIR_RIGHT   = 3'd4;

  typedef struct packed {
    logic [NEUTRAL_W-1:0] neutral_x;
    logic [NEUTRAL_W-1:0] neutral_y;
    logic [LIMIT_W-1:0]   dead_zone;
    logic [LIMIT_W-1:0]   cross_limit;
  } cfg_t;

endpackage

/* rtl/joystick_scale_and_direction.sv */
// Top level of the joystick scale and direction decoder.
// Depends on jsd_pkg, jsd_regs, jsd_front, jsd_queue, jsd_back and the assert header.
//
// Takes one sample pair per cycle while full is low and returns one result beat
// per pair, in order. Each axis becomes a signed percent (-100..100) of its
// deflection from the programmed neutral, truncated toward zero, and a direction
// code is decoded from both. With pop held high a pair passes through one front
// register, one slot in the two-beat queue, a load stage and seven divider stages
// (one quotient bit each, a compare and subtract per axis), then the output
// register. Throughput is one beat per cycle; when the output is held, the
// pipeline freezes and the front register and queue absorb up to three more beats
// before full rises. Program registers only while no beat is in flight.
module joystick_scale_and_direction #(
  parameter int SAMPLE_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [jsd_pkg::ADDR_W-1:0]       paddr,
  input  logic [jsd_pkg::DATA_W-1:0]       pwdata,
  output logic [jsd_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  input  logic                             push,
  output logic                             full,
  input  logic [SAMPLE_BITS-1:0]           sample_x,
  input  logic [SAMPLE_BITS-1:0]           sample_y,
  input  logic                             pop,
  output logic                             empty,
  output logic signed [jsd_pkg::PCT_W-1:0] percent_x,
  output logic signed [jsd_pkg::PCT_W-1:0] percent_y,
  output logic [jsd_pkg::DIR_W-1:0]        direction
);

  `include "joystick_scale_and_direction_assert.svh"

  localparam int NUM_W  = SAMPLE_BITS + jsd_pkg::QUOT_BITS;
  localparam int AX_W   = 2 + NUM_W + SAMPLE_BITS;
  localparam int ITEM_W = 2 * AX_W;

  jsd_pkg::cfg_t     cfg;
  logic              q_push;
  logic              q_full;
  logic              q_empty;
  logic              q_take;
  logic [ITEM_W-1:0] q_wdata;
  logic [ITEM_W-1:0] q_rdata;

  jsd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jsd_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .full     (full),
    .sample_x (sample_x),
    .sample_y (sample_y),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_data   (q_wdata)
  );

  jsd_queue #(.WIDTH(ITEM_W), .DEPTH(jsd_pkg::MID_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_take),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  jsd_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (!q_empty),
    .item       (q_rdata),
    .item_take  (q_take),
    .pop        (pop),
    .empty      (empty),
    .percent_x  (percent_x),
    .percent_y  (percent_y),
    .direction  (direction)
  );

  `JSD_CHECK_AFTER_RESET(a_reset_clears, empty && !full)
  `JSD_CHECK_IMPL(a_x_range, !empty, percent_x >= -8'sd100 && percent_x <= 8'sd100)
  `JSD_CHECK_IMPL(a_y_range, !empty, percent_y >= -8'sd100 && percent_y <= 8'sd100)
  `JSD_CHECK_IMPL(a_down_sign, !empty && direction == jsd_pkg::DIR_DOWN, percent_y < 0)

endmodule

/* rtl/jsd_regs.sv */
// Configuration register file with an APB-style slave port.
// Depends on jsd_pkg.
module jsd_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [jsd_pkg::ADDR_W-1:0] paddr,
  input  logic [jsd_pkg::DATA_W-1:0] pwdata,
  output logic [jsd_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output jsd_pkg::cfg_t              cfg
);

  logic       wr_fire;
  logic [1:0] index;

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite;
  assign index   = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.neutral_x   <= jsd_pkg::NEUTRAL_RESET;
      cfg.neutral_y   <= jsd_pkg::NEUTRAL_RESET;
      cfg.dead_zone   <= jsd_pkg::DEAD_ZONE_RESET;
      cfg.cross_limit <= jsd_pkg::CROSS_LIMIT_RESET;
    end else if (wr_fire) begin
      case (index)
        jsd_pkg::REG_NEUTRAL_X:   cfg.neutral_x   <= pwdata[jsd_pkg::NEUTRAL_W-1:0];
        jsd_pkg::REG_NEUTRAL_Y:   cfg.neutral_y   <= pwdata[jsd_pkg::NEUTRAL_W-1:0];
        jsd_pkg::REG_DEAD_ZONE:   cfg.dead_zone   <= pwdata[jsd_pkg::LIMIT_W-1:0];
        jsd_pkg::REG_CROSS_LIMIT: cfg.cross_limit <= pwdata[jsd_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      jsd_pkg::REG_NEUTRAL_X:   prdata = jsd_pkg::DATA_W'(cfg.neutral_x);
      jsd_pkg::REG_NEUTRAL_Y:   prdata = jsd_pkg::DATA_W'(cfg.neutral_y);
      jsd_pkg::REG_DEAD_ZONE:   prdata = jsd_pkg::DATA_W'(cfg.dead_zone);
      jsd_pkg::REG_CROSS_LIMIT: prdata = jsd_pkg::DATA_W'(cfg.cross_limit);
      default:                  prdata = '0;
    endcase
  end

endmodule

/* rtl/jsd_front.sv */
// Front end: takes a sample pair and splits each axis into sign, zero-span
// flag, span and scaled offset for the divider. Depends on jsd_pkg.
module jsd_front #(
  parameter int SAMPLE_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  jsd_pkg::cfg_t          cfg,
  input  logic                   push,
  output logic                   full,
  input  logic [SAMPLE_BITS-1:0] sample_x,
  input  logic [SAMPLE_BITS-1:0] sample_y,
  output logic                   q_push,
  input  logic                   q_full,
  output logic [2*(2+SAMPLE_BITS+jsd_pkg::QUOT_BITS+SAMPLE_BITS)-1:0] q_data
);

  localparam int NUM_W  = SAMPLE_BITS + jsd_pkg::QUOT_BITS;
  localparam int AX_W   = 2 + NUM_W + SAMPLE_BITS;
  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;
  localparam logic [NUM_W-1:0]       HUNDRED    = NUM_W'(jsd_pkg::PCT_FULL);

  logic                   front_valid;
  logic                   take;
  logic [SAMPLE_BITS-1:0] nx;
  logic [SAMPLE_BITS-1:0] ny;

  // packed axis beat: {neg, zero_span, 100*offset, span}
  function automatic logic [AX_W-1:0] classify(logic [SAMPLE_BITS-1:0] s,
                                               logic [SAMPLE_BITS-1:0] n);
    logic                   gt;
    logic [SAMPLE_BITS-1:0] diff;
    logic [SAMPLE_BITS-1:0] span;
    logic [NUM_W-1:0]       num;
    gt   = s > n;
    diff = gt ? s - n : n - s;
    span = gt ? FULL_SCALE - n : n;
    num  = NUM_W'(diff) * HUNDRED;
    return {~gt, (span == '0), num, span};
  endfunction

  assign nx     = SAMPLE_BITS'(cfg.neutral_x);
  assign ny     = SAMPLE_BITS'(cfg.neutral_y);
  assign q_push = front_valid && !q_full;
  assign full   = front_valid && q_full;
  assign take   = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (take) begin
      front_valid <= 1'b1;
    end else if (q_push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_data <= {classify(sample_y, ny), classify(sample_x, nx)};
    end
  end

endmodule

/* rtl/jsd_queue.sv */
// Short FIFO that decouples the front end from the divider pipeline.
// No dependencies.
module jsd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

/* rtl/jsd_back.sv */
// Back end: one restoring divider pipeline per axis, then sign, direction
// decode and the output register. Depends on jsd_pkg.
module jsd_back #(
  parameter int SAMPLE_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  jsd_pkg::cfg_t               cfg,
  input  logic                        item_valid,
  input  logic [2*(2+SAMPLE_BITS+jsd_pkg::QUOT_BITS+SAMPLE_BITS)-1:0] item,
  output logic                        item_take,
  input  logic                        pop,
  output logic                        empty,
  output logic signed [jsd_pkg::PCT_W-1:0] percent_x,
  output logic signed [jsd_pkg::PCT_W-1:0] percent_y,
  output logic [jsd_pkg::DIR_W-1:0]   direction
);

  localparam int QB     = jsd_pkg::QUOT_BITS;
  localparam int NUM_W  = SAMPLE_BITS + QB;
  localparam int AX_W   = 2 + NUM_W + SAMPLE_BITS;

  logic [NUM_W-1:0]       rem   [0:1][0:QB];
  logic [SAMPLE_BITS-1:0] span  [0:1][0:QB];
  logic [QB-1:0]          quot  [0:1][0:QB];
  logic                   neg   [0:1][0:QB];
  logic                   zero  [0:1][0:QB];
  logic                   valid [0:QB];

  logic [NUM_W-1:0]       rem_n  [0:1][0:QB-1];
  logic [QB-1:0]          quot_n [0:1][0:QB-1];

  logic signed [jsd_pkg::PCT_W-1:0] pct [0:1];
  logic [jsd_pkg::DIR_W-1:0]        dir;
  logic                             out_valid;
  logic                             advance;

  function automatic logic in_band(logic signed [jsd_pkg::PCT_W-1:0] v,
                                   logic [jsd_pkg::LIMIT_W-1:0] lim);
    logic signed [jsd_pkg::PCT_W:0] vv;
    logic signed [jsd_pkg::PCT_W:0] ll;
    vv = $signed({v[jsd_pkg::PCT_W-1], v});
    ll = $signed({2'b00, lim});
    return (-ll < vv) && (vv < ll);
  endfunction

  // whole pipeline moves together; bubbles are not squeezed out
  assign advance   = !out_valid || pop;
  assign item_take = advance && item_valid;
  assign empty     = !out_valid;

  // one quotient bit per stage, most significant first
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      for (int j = 0; j < QB; j++) begin
        logic [NUM_W-1:0] trial;
        logic             ge;
        trial = NUM_W'(span[a][j]) << (QB - 1 - j);
        ge    = rem[a][j] >= trial;
        rem_n[a][j]  = ge ? rem[a][j] - trial : rem[a][j];
        quot_n[a][j] = {quot[a][j][QB-2:0], ge};
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      if (zero[a][QB]) begin
        pct[a] = '0;
      end else if (neg[a][QB]) begin
        pct[a] = -$signed({1'b0, quot[a][QB]});
      end else begin
        pct[a] = $signed({1'b0, quot[a][QB]});
      end
    end
  end

  always_comb begin
    if (in_band(pct[0], cfg.dead_zone) && in_band(pct[1], cfg.dead_zone)) begin
      dir = jsd_pkg::DIR_NEUTRAL;
    end else if (pct[1] < 0 && in_band(pct[0], cfg.cross_limit)) begin
      dir = jsd_pkg::DIR_DOWN;
    end else if (pct[1] > 0 && in_band(pct[0], cfg.cross_limit)) begin
      dir = jsd_pkg::DIR_UP;
    end else if (pct[0] < 0 && in_band(pct[1], cfg.cross_limit)) begin
      dir = jsd_pkg::DIR_LEFT;
    end else if (pct[0] > 0 && in_band(pct[1], cfg.cross_limit)) begin
      dir = jsd_pkg::DIR_RIGHT;
    end else begin
      dir = jsd_pkg::DIR_NEUTRAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= QB; j++) begin
        valid[j] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (advance) begin
      valid[0] <= item_valid;
      for (int j = 0; j < QB; j++) begin
        valid[j+1] <= valid[j];
      end
      out_valid <= valid[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int a = 0; a < 2; a++) begin
        span[a][0] <= item[a*AX_W +: SAMPLE_BITS];
        rem[a][0]  <= item[a*AX_W + SAMPLE_BITS +: NUM_W];
        zero[a][0] <= item[a*AX_W + SAMPLE_BITS + NUM_W];
        neg[a][0]  <= item[a*AX_W + SAMPLE_BITS + NUM_W + 1];
        quot[a][0] <= '0;
        for (int j = 0; j < QB; j++) begin
          span[a][j+1] <= span[a][j];
          rem[a][j+1]  <= rem_n[a][j];
          quot[a][j+1] <= quot_n[a][j];
          zero[a][j+1] <= zero[a][j];
          neg[a][j+1]  <= neg[a][j];
        end
      end
      percent_x <= pct[0];
      percent_y <= pct[1];
      direction <= dir;
    end
  end

endmodule

/* tb/tb_top.sv */
// Self-checking bench for joystick_scale_and_direction: random and directed sample pairs,
// with register writes over APB, checked against a local percent/direction predictor.
// Depends on jsd_pkg and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [jsd_pkg::PCT_W-1:0] pct_x;
    logic signed [jsd_pkg::PCT_W-1:0] pct_y;
    logic [jsd_pkg::DIR_W-1:0]        dir;
  } reading_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       psel, penable, pwrite;
  logic [jsd_pkg::ADDR_W-1:0] paddr;
  logic [jsd_pkg::DATA_W-1:0] pwdata;
  logic [jsd_pkg::DATA_W-1:0] prdata;
  logic                       pready;
  logic                       push;
  logic                       full;
  logic [7:0]                 sample_x, sample_y;
  logic                       pop = 1'b0;
  logic                       empty;
  logic signed [jsd_pkg::PCT_W-1:0] percent_x, percent_y;
  logic [jsd_pkg::DIR_W-1:0]  direction;

  jsd_pkg::cfg_t cfg_shadow;
  reading_t      pending_readings[$];
  int            mismatches = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  logic          hold_off = 1'b0;

  joystick_scale_and_direction uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full), .sample_x(sample_x), .sample_y(sample_y),
    .pop(pop), .empty(empty),
    .percent_x(percent_x), .percent_y(percent_y), .direction(direction)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // signed percent of one axis, truncated toward zero
  function automatic logic signed [jsd_pkg::PCT_W-1:0] axis_percent(logic [7:0] s,
                                                                    logic [7:0] n);
    int mag;
    if (s > n) begin
      mag = (100 * (int'(s) - int'(n))) / (255 - int'(n));
      return jsd_pkg::PCT_W'(mag);
    end
    if (n == 0) return '0;
    mag = (100 * (int'(n) - int'(s))) / int'(n);
    return jsd_pkg::PCT_W'(-mag);
  endfunction

  function automatic bit within_band(int v, int lim);
    return (-lim < v) && (v < lim);
  endfunction

  function automatic reading_t decode_reading(logic [7:0] sx, logic [7:0] sy);
    reading_t r;
    int px, py, dz, cl;
    r.pct_x = axis_percent(sx, cfg_shadow.neutral_x);
    r.pct_y = axis_percent(sy, cfg_shadow.neutral_y);
    px = r.pct_x;
    py = r.pct_y;
    dz = cfg_shadow.dead_zone;
    cl = cfg_shadow.cross_limit;
    if (within_band(px, dz) && within_band(py, dz)) r.dir = jsd_pkg::DIR_NEUTRAL;
    else if (py < 0 && within_band(px, cl))        r.dir = jsd_pkg::DIR_DOWN;
    else if (py > 0 && within_band(px, cl))        r.dir = jsd_pkg::DIR_UP;
    else if (px < 0 && within_band(py, cl))        r.dir = jsd_pkg::DIR_LEFT;
    else if (px > 0 && within_band(py, cl))        r.dir = jsd_pkg::DIR_RIGHT;
    else                                           r.dir = jsd_pkg::DIR_NEUTRAL;
    return r;
  endfunction

  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endtask

  // receiver side: random stalls, plus the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    reading_t got, want;
    if (!rst && pop && !empty) begin
      got.pct_x = percent_x;
      got.pct_y = percent_y;
      got.dir   = direction;
      if (pending_readings.size() == 0) begin
        log_mismatch($sformatf("unexpected beat x=%0d y=%0d dir=%0d",
                               got.pct_x, got.pct_y, got.dir));
      end else begin
        want = pending_readings.pop_front();
        if (got !== want)
          log_mismatch($sformatf("x exp %0d got %0d, y exp %0d got %0d, dir exp %0d got %0d",
                                 want.pct_x, got.pct_x, want.pct_y, got.pct_y,
                                 want.dir, got.dir));
      end
    end
  end

  // called at a rising edge; returns at the edge where the pair is accepted
  task automatic send_pair(logic [7:0] sx, logic [7:0] sy);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push     <= 1'b1;
    sample_x <= sx;
    sample_y <= sy;
    do @(posedge clk); while (full);
    pending_readings.push_back(decode_reading(sx, sy));
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    logic [jsd_pkg::DATA_W-1:0] masked;
    masked = jsd_pkg::DATA_W'((idx == jsd_pkg::REG_DEAD_ZONE ||
                               idx == jsd_pkg::REG_CROSS_LIMIT) ? (val & 8'h7f) : val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= masked;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== masked)
      log_mismatch($sformatf("reg %0d readback exp %0d got %0d", idx, masked, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      jsd_pkg::REG_NEUTRAL_X:   cfg_shadow.neutral_x   = masked[7:0];
      jsd_pkg::REG_NEUTRAL_Y:   cfg_shadow.neutral_y   = masked[7:0];
      jsd_pkg::REG_DEAD_ZONE:   cfg_shadow.dead_zone   = masked[6:0];
      jsd_pkg::REG_CROSS_LIMIT: cfg_shadow.cross_limit = masked[6:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [7:0] nx, logic [7:0] ny, logic [6:0] dz, logic [6:0] cl);
    wait_idle();
    write_reg(jsd_pkg::REG_NEUTRAL_X, nx);
    write_reg(jsd_pkg::REG_NEUTRAL_Y, ny);
    write_reg(jsd_pkg::REG_DEAD_ZONE, {1'b0, dz});
    write_reg(jsd_pkg::REG_CROSS_LIMIT, {1'b0, cl});
  endtask

  function automatic logic [7:0] pick_sample(logic [7:0] n);
    int v;
    case ($urandom_range(0, 9))
      6, 7: v = int'(n) + int'($urandom_range(0, 40)) - 20;   // near the rest position
      8, 9: begin
        case ($urandom_range(0, 3))
          0: v = 0;
          1: v = 255;
          2: v = 1;
          default: v = 254;
        endcase
      end
      default: v = $urandom_range(0, 255);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic logic [7:0] pick_neutral();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [6:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 7'd0;
      1: return 7'd100;
      2: return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic test_reset_config();
    send_pair(8'd128, 8'd128);
    send_pair(8'd128, 8'd0);
    send_pair(8'd128, 8'd255);
    send_pair(8'd0,   8'd128);
    send_pair(8'd255, 8'd128);
    send_pair(8'd0,   8'd0);
    send_pair(8'd255, 8'd255);
    send_pair(8'd0,   8'd255);
    send_pair(8'd255, 8'd0);
  endtask

  // neutral at either rail: zero span on the low side, no high side at all
  task automatic test_rail_neutrals();
    set_config(8'd0, 8'd255, 7'd10, 7'd50);
    send_pair(8'd0,   8'd255);
    send_pair(8'd255, 8'd0);
    send_pair(8'd1,   8'd254);
    send_pair(8'd0,   8'd0);
    set_config(8'd255, 8'd0, 7'd10, 7'd50);
    send_pair(8'd255, 8'd0);
    send_pair(8'd0,   8'd255);
    send_pair(8'd254, 8'd1);
  endtask

  task automatic test_limit_extremes();
    set_config(8'd128, 8'd128, 7'd0, 7'd0);
    send_pair(8'd128, 8'd128);
    send_pair(8'd129, 8'd130);
    send_pair(8'd200, 8'd128);
    set_config(8'd128, 8'd128, 7'd127, 7'd127);
    send_pair(8'd0,   8'd0);
    send_pair(8'd255, 8'd255);
    set_config(8'd127, 8'd129, 7'd100, 7'd100);
    send_pair(8'd0,   8'd255);
    send_pair(8'd255, 8'd0);
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int count);
    set_config(pick_neutral(), pick_neutral(), pick_limit(), pick_limit());
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2)
        set_config(pick_neutral(), pick_neutral(), pick_limit(), pick_limit());
      send_pair(pick_sample(cfg_shadow.neutral_x), pick_sample(cfg_shadow.neutral_y));
    end
  endtask

  // output held off for a long stretch while pairs keep coming, so full must rise
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    for (int i = 0; i < 60; i++)
      send_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  initial begin
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    push     = 1'b0;
    sample_x = '0;
    sample_y = '0;
    cfg_shadow = '{jsd_pkg::NEUTRAL_RESET, jsd_pkg::NEUTRAL_RESET,
                   jsd_pkg::DEAD_ZONE_RESET, jsd_pkg::CROSS_LIMIT_RESET};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_config();
    test_rail_neutrals();
    test_limit_extremes();
    test_random_phase(0, 0, 400);
    test_random_phase(76, 0, 400);
    test_random_phase(0, 76, 400);
    test_random_phase(19, 19, 400);
    test_backpressure();

    wait_idle();
    repeat (15) @(posedge clk);
    if (pending_readings.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", pending_readings.size()));
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
